@@ sv/ppbc_pkg.sv @@
`timescale 1ns / 1ps

package ppbc_pkg;

    localparam int DEPTH_DEF      = 9;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int BAND_W    = 20;
    localparam int FREQ_W    = 20;
    localparam int PERIOD_W  = 32;
    localparam int CLASS_W   = 2;
    localparam int STATUS_W  = 2;

    // serial divider: dividend/quotient shift register and divisor widths
    localparam int DIVD_W    = 32;
    localparam int DIVS_W    = 17;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B_HIGH   = 3'd5;

    localparam logic [CFG_W-1:0]  MAX_SPAN_RST = 32'd200000;
    localparam logic [CFG_W-1:0]  MAX_AGE_RST  = 32'd1000000;
    localparam logic [BAND_W-1:0] A_LOW_RST    = 20'd830;
    localparam logic [BAND_W-1:0] A_HIGH_RST   = 20'd870;
    localparam logic [BAND_W-1:0] B_LOW_RST    = 20'd3900;
    localparam logic [BAND_W-1:0] B_HIGH_RST   = 20'd4100;

    localparam logic FUNC_EDGE  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SEQ   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_ENEMY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SPAN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_LIMIT  = 32'd100000;
    localparam logic [DIVD_W-1:0]   ONE_SECOND_US = 32'd1000000;
    // aligned so that FREQ_W steps leave the quotient in the low bits
    localparam logic [DIVD_W-1:0]   FREQ_DIVIDEND = ONE_SECOND_US << (DIVD_W - FREQ_W);

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIVD_W-1:0]    dividend;
        logic [DIVS_W-1:0]    divisor;
    } div_req_t;

endpackage

@@ sv/ppbc_ring.sv @@
`timescale 1ns / 1ps

module ppbc_ring #(
    parameter int DEPTH      = 9,
    parameter int TIME_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [TIME_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [TIME_WIDTH-1:0] rd_data
);

    logic [TIME_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic [TIME_WIDTH-1:0] mem_q_reg;
    logic                  vld_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
            vld_q_reg <= valid_reg[rd_addr];
        end
    end

    // unwritten slots read as zero
    assign rd_data = vld_q_reg ? mem_q_reg : '0;

endmodule

@@ sv/ppbc_serdiff.sv @@
`timescale 1ns / 1ps

module ppbc_serdiff #(
    parameter int TIME_WIDTH = 32,
    parameter int CW         = (TIME_WIDTH > ppbc_pkg::CFG_W) ? TIME_WIDTH : ppbc_pkg::CFG_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic [TIME_WIDTH-1:0]      a,
    input  logic [TIME_WIDTH-1:0]      b,
    input  logic [ppbc_pkg::CFG_W-1:0] limit,
    output logic                       busy,
    output logic [CW-1:0]              diff,
    output logic                       over
);

    import ppbc_pkg::*;

    localparam int CNT_W = $clog2(CW + 1);

    logic [CW-1:0]    a_reg;
    logic [CW-1:0]    b_reg;
    logic [CW-1:0]    lim_reg;
    logic [CW-1:0]    diff_reg;
    logic             bor_d_reg;
    logic             bor_c_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic da, db, lb, in_range, dbit;
    logic bor_d_next, bor_c_next;

    // LSB first: a - b, wrapped to TIME_WIDTH, and in the same pass limit - diff for the compare
    always_comb begin
        da         = a_reg[0];
        db         = b_reg[0];
        lb         = lim_reg[0];
        in_range   = cnt_reg > CNT_W'(CW - TIME_WIDTH);
        dbit       = in_range & (da ^ db ^ bor_d_reg);
        bor_d_next = (~da & db) | (~(da ^ db) & bor_d_reg);
        bor_c_next = (~lb & dbit) | (~(lb ^ dbit) & bor_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= CNT_W'(CW);
        end else if (busy) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg     <= CW'(a);
            b_reg     <= CW'(b);
            lim_reg   <= CW'(limit);
            bor_d_reg <= 1'b0;
            bor_c_reg <= 1'b0;
        end else if (busy) begin
            a_reg     <= a_reg >> 1;
            b_reg     <= b_reg >> 1;
            lim_reg   <= lim_reg >> 1;
            diff_reg  <= {dbit, diff_reg[CW-1:1]};
            bor_d_reg <= bor_d_next;
            bor_c_reg <= bor_c_next;
        end
    end

    assign busy = cnt_reg != '0;
    assign diff = diff_reg;
    assign over = bor_c_reg;

endmodule

@@ sv/ppbc_serdiv.sv @@
`timescale 1ns / 1ps

module ppbc_serdiv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ppbc_pkg::div_req_t          req,
    output logic                        busy,
    output logic [ppbc_pkg::DIVD_W-1:0] quotient
);

    import ppbc_pkg::*;

    logic [DIVD_W-1:0]    q_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [DIVS_W-1:0]    d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   sub;
    logic              qbit;
    logic [DIVS_W-1:0] rem_next;

    // restoring radix-2 step
    always_comb begin
        trial    = {rem_reg, q_reg[DIVD_W-1]};
        sub      = trial - {1'b0, d_reg};
        qbit     = trial >= {1'b0, d_reg};
        rem_next = qbit ? sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (req.start) begin
            cnt_reg <= req.steps;
        end else if (busy) begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_reg   <= req.dividend;
            d_reg   <= req.divisor;
            rem_reg <= '0;
        end else if (busy) begin
            q_reg   <= {q_reg[DIVD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule

@@ sv/pulse_period_beacon_classifier_top.sv @@
`timescale 1ns / 1ps

// Pulse period beacon classifier.
// Input channel s_*: s_func = 0 records the edge time s_time_us in a ring of
// DEPTH slots and gives no result; s_func = 1 is a query at time s_time_us.
// Result channel m_*: one transfer per query with class, frequency, period
// and status. Registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, which the block
// itself does not enforce; indexes above 5 are ignored. Edge items take
// one cycle each while the block is idle. A passing query runs two ring
// reads, a bit-serial subtract and limit compare over CW bits, where
// CW = max(TIME_WIDTH, 32), a check step, the 32-step radix-2 period
// division, the 20-step frequency division, classification and the output
// load. A span or age failure ends after the check, a period out of range
// after the period division. s_ready is low while a query runs.
// A finished result waits in the output register; the block keeps taking
// edges and may run the next query meanwhile, holding only before it would
// overwrite a result not yet taken.
// Reset clears the ring (valid flags), the write index, pending results and
// restores the register defaults.

module pulse_period_beacon_classifier_top #(
    parameter int DEPTH      = ppbc_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = ppbc_pkg::TIME_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ppbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppbc_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [TIME_WIDTH-1:0]         s_time_us,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ppbc_pkg::CLASS_W-1:0]  m_target_class,
    output logic [ppbc_pkg::FREQ_W-1:0]   m_freq_hz,
    output logic [ppbc_pkg::PERIOD_W-1:0] m_period_us,
    output logic [ppbc_pkg::STATUS_W-1:0] m_status
);

    import ppbc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_NEW,
        S_LOAD,
        S_SUB,
        S_CHECK,
        S_PDIV,
        S_FDIV,
        S_CLASS,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]  max_span_reg;
    logic [CFG_W-1:0]  max_age_reg;
    logic [BAND_W-1:0] a_low_reg;
    logic [BAND_W-1:0] a_high_reg;
    logic [BAND_W-1:0] b_low_reg;
    logic [BAND_W-1:0] b_high_reg;

    logic [AW-1:0]         write_index_reg;
    logic [AW-1:0]         newest_addr_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [TIME_WIDTH-1:0] oldest_reg;

    logic [CLASS_W-1:0]  res_class_reg;
    logic [FREQ_W-1:0]   res_freq_reg;
    logic [PERIOD_W-1:0] res_period_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic                m_valid_reg;
    logic [CLASS_W-1:0]  m_target_class_reg;
    logic [FREQ_W-1:0]   m_freq_hz_reg;
    logic [PERIOD_W-1:0] m_period_us_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic                  in_xfer;
    logic                  edge_xfer;
    logic                  query_xfer;
    logic                  ring_rd_en;
    logic [AW-1:0]         ring_rd_addr;
    logic [TIME_WIDTH-1:0] ring_rd_data;
    logic                  sub_load;
    logic                  span_busy;
    logic                  span_over;
    logic [CW-1:0]         span_diff;
    logic                  age_busy;
    logic                  age_over;
    div_req_t              div_req;
    logic                  div_busy;
    logic [DIVD_W-1:0]     div_quot;
    logic                  period_ok;

    assign s_ready    = state_reg == S_IDLE;
    assign in_xfer    = s_valid && s_ready;
    assign edge_xfer  = in_xfer && (s_func == FUNC_EDGE);
    assign query_xfer = in_xfer && (s_func == FUNC_QUERY);

    assign ring_rd_en   = query_xfer || (state_reg == S_RD_NEW);
    assign ring_rd_addr = (state_reg == S_IDLE) ? write_index_reg : newest_addr_reg;
    assign sub_load     = state_reg == S_LOAD;

    assign period_ok = (div_quot != '0) && (div_quot < PERIOD_LIMIT);

    always_comb begin
        div_req = '0;
        if (state_reg == S_CHECK && !span_over && !age_over) begin
            div_req.start    = 1'b1;
            div_req.steps    = DIV_CNT_W'(DIVD_W);
            div_req.dividend = span_diff[DIVD_W-1:0];
            div_req.divisor  = DIVS_W'(DEPTH - 1);
        end else if (state_reg == S_PDIV && !div_busy && period_ok) begin
            div_req.start    = 1'b1;
            div_req.steps    = DIV_CNT_W'(FREQ_W);
            div_req.dividend = FREQ_DIVIDEND;
            div_req.divisor  = div_quot[DIVS_W-1:0];
        end
    end

    ppbc_ring #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH),
        .AW         (AW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (edge_xfer),
        .wr_addr (write_index_reg),
        .wr_data (s_time_us),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    ppbc_serdiff #(
        .TIME_WIDTH (TIME_WIDTH),
        .CW         (CW)
    ) u_span (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (sub_load),
        .a       (ring_rd_data),
        .b       (oldest_reg),
        .limit   (max_span_reg),
        .busy    (span_busy),
        .diff    (span_diff),
        .over    (span_over)
    );

    ppbc_serdiff #(
        .TIME_WIDTH (TIME_WIDTH),
        .CW         (CW)
    ) u_age (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (sub_load),
        .a       (now_reg),
        .b       (oldest_reg),
        .limit   (max_age_reg),
        .busy    (age_busy),
        .diff    (),
        .over    (age_over)
    );

    ppbc_serdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_span_reg <= MAX_SPAN_RST;
            max_age_reg  <= MAX_AGE_RST;
            a_low_reg    <= A_LOW_RST;
            a_high_reg   <= A_HIGH_RST;
            b_low_reg    <= B_LOW_RST;
            b_high_reg   <= B_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_SPAN: max_span_reg <= cfg_wdata;
                CFG_MAX_AGE:  max_age_reg  <= cfg_wdata;
                CFG_A_LOW:    a_low_reg    <= cfg_wdata[BAND_W-1:0];
                CFG_A_HIGH:   a_high_reg   <= cfg_wdata[BAND_W-1:0];
                CFG_B_LOW:    b_low_reg    <= cfg_wdata[BAND_W-1:0];
                CFG_B_HIGH:   b_high_reg   <= cfg_wdata[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            write_index_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // S_DONE reloads the output itself whenever the slot frees
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (edge_xfer) begin
                        write_index_reg <= (write_index_reg == AW'(DEPTH - 1)) ?
                                           '0 : write_index_reg + AW'(1);
                    end else if (query_xfer) begin
                        newest_addr_reg <= (write_index_reg == '0) ?
                                           AW'(DEPTH - 1) : write_index_reg - AW'(1);
                        now_reg         <= s_time_us;
                        write_index_reg <= '0;
                        state_reg       <= S_RD_NEW;
                    end
                end
                S_RD_NEW: begin
                    oldest_reg <= ring_rd_data;
                    state_reg  <= S_LOAD;
                end
                S_LOAD: begin
                    state_reg <= S_SUB;
                end
                S_SUB: begin
                    if (!span_busy && !age_busy) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    res_class_reg  <= CLASS_NONE;
                    res_freq_reg   <= '0;
                    res_period_reg <= '0;
                    if (span_over) begin
                        res_status_reg <= ST_SPAN;
                        state_reg      <= S_DONE;
                    end else if (age_over) begin
                        res_status_reg <= ST_STALE;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (!div_busy) begin
                        res_period_reg <= div_quot[PERIOD_W-1:0];
                        if (period_ok) begin
                            state_reg <= S_FDIV;
                        end else begin
                            res_status_reg <= ST_RANGE;
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_FDIV: begin
                    if (!div_busy) begin
                        res_freq_reg <= div_quot[FREQ_W-1:0];
                        state_reg    <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    res_status_reg <= ST_OK;
                    if (a_low_reg < res_freq_reg && res_freq_reg < a_high_reg) begin
                        res_class_reg <= CLASS_ENEMY;
                    end else if (b_low_reg < res_freq_reg && res_freq_reg < b_high_reg) begin
                        res_class_reg <= CLASS_SEQ;
                    end else begin
                        res_class_reg <= CLASS_NONE;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_target_class_reg <= res_class_reg;
                        m_freq_hz_reg      <= res_freq_reg;
                        m_period_us_reg    <= res_period_reg;
                        m_status_reg       <= res_status_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_target_class = m_target_class_reg;
    assign m_freq_hz      = m_freq_hz_reg;
    assign m_period_us    = m_period_us_reg;
    assign m_status       = m_status_reg;

`ifndef SYNTH
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        write_index_reg <= AW'(DEPTH - 1))
        else $error("write index beyond ring depth");

    a_query_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        query_xfer |=> write_index_reg == '0)
        else $error("write index not rewound after query");

    a_fail_no_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |->
        (m_freq_hz_reg == '0 && m_target_class_reg == CLASS_NONE))
        else $error("failed query reports a frequency or class");

    a_fail_no_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_SPAN || m_status_reg == ST_STALE)) |->
        m_period_us_reg == '0)
        else $error("span or age failure reports a period");
`endif

endmodule
